// File: hw/rtl/lzce_pkg.sv
// shared types and constants for the laplacian zero-crossing edge unit
package lzce_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = 13;
    localparam int GRAY_W    = 8;
    localparam int LAP_W     = 11;
    localparam int THR_W     = 10;
    localparam int LVL_W     = 2;

    localparam int IMG_W_RESET = 321;
    localparam int IMG_H_RESET = 481;
    localparam int THR_RESET   = 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_THRESHOLD    = 2'd2
    } lzce_reg_idx_t;

    // level codes as they appear on the result port and in the line store
    localparam logic [LVL_W-1:0] LV_ZERO = 2'd0;
    localparam logic [LVL_W-1:0] LV_POS  = 2'd1;
    localparam logic [LVL_W-1:0] LV_NEG  = 2'd2;

    // window position against the frame border
    typedef struct packed {
        logic top;
        logic bot;
        logic left;
        logic right;
    } lzce_pos_t;

    // what travels with a step for the final window
    typedef struct packed {
        logic      emit;
        logic      last;
        lzce_pos_t pos;
    } lzce_tag_t;

    typedef struct packed {
        logic signed [LAP_W-1:0] lap;
        logic [LVL_W-1:0]        level;
        logic                    edge_res;
        logic                    last;
    } lzce_result_t;

endpackage

// File: hw/rtl/lzce_lap_stage.sv
// gray line store, 3x3 gray window and laplacian / threshold stage
module lzce_lap_stage #(
    parameter int MAX_WIDTH = lzce_pkg::DEF_MAX_WIDTH,
    parameter int CW        = $clog2(MAX_WIDTH)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              flush,
    input  logic                              step,
    input  logic [CW-1:0]                     col,
    input  logic [lzce_pkg::GRAY_W-1:0]       pix,
    input  lzce_pkg::lzce_pos_t               a_pos,
    input  logic [CW-1:0]                     a_col,
    input  lzce_pkg::lzce_tag_t               b_tag,
    input  logic [lzce_pkg::THR_W-1:0]        thr,
    output logic                              lv_valid,
    output logic signed [lzce_pkg::LAP_W-1:0] lv_lap,
    output logic [lzce_pkg::LVL_W-1:0]        lv_code,
    output logic [CW-1:0]                     lv_col,
    output lzce_pkg::lzce_tag_t               lv_tag
);

    localparam int GW = lzce_pkg::GRAY_W;

    // each entry holds the two previous rows of one column: {older, newer}
    logic [2*GW-1:0] gray_mem [MAX_WIDTH];
    logic [2*GW-1:0] gray_rd_reg;

    logic                s1_valid_reg;
    logic [GW-1:0]       s1_pix_reg;
    logic [CW-1:0]       s1_col_reg;
    lzce_pkg::lzce_pos_t s1_pos_reg;
    logic [CW-1:0]       s1_acol_reg;
    lzce_pkg::lzce_tag_t s1_tag_reg;

    logic                s2_valid_reg;
    lzce_pkg::lzce_pos_t s2_pos_reg;
    logic [CW-1:0]       s2_acol_reg;
    lzce_pkg::lzce_tag_t s2_tag_reg;

    logic                              s3_valid_reg;
    logic signed [lzce_pkg::LAP_W-1:0] s3_lap_reg;
    logic [lzce_pkg::LVL_W-1:0]        s3_code_reg;
    logic [CW-1:0]                     s3_col_reg;
    lzce_pkg::lzce_tag_t               s3_tag_reg;

    // window [column][row], column 0 is left, row 0 is top
    logic [2:0][2:0][GW-1:0] gw_reg;

    logic [GW-1:0]      up_px, down_px, left_px, right_px, mid_px;
    logic signed [11:0] lap_w;
    logic signed [11:0] thr_s;
    logic [lzce_pkg::LVL_W-1:0] code_w;

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            gray_rd_reg <= gray_mem[col];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            gray_mem[s1_col_reg] <= {gray_rd_reg[GW-1:0], s1_pix_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (flush)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= step;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pix_reg  <= pix;
            s1_col_reg  <= col;
            s1_pos_reg  <= a_pos;
            s1_acol_reg <= a_col;
            s1_tag_reg  <= b_tag;
            s2_pos_reg  <= s1_pos_reg;
            s2_acol_reg <= s1_acol_reg;
            s2_tag_reg  <= s1_tag_reg;
            s3_lap_reg  <= lap_w[lzce_pkg::LAP_W-1:0];
            s3_code_reg <= code_w;
            s3_col_reg  <= s2_acol_reg;
            s3_tag_reg  <= s2_tag_reg;
        end
        if (adv && s1_valid_reg)
        begin
            gw_reg[0]    <= gw_reg[1];
            gw_reg[1]    <= gw_reg[2];
            gw_reg[2][0] <= gray_rd_reg[2*GW-1:GW];
            gw_reg[2][1] <= gray_rd_reg[GW-1:0];
            gw_reg[2][2] <= s1_pix_reg;
        end
    end

    // mirrored borders: the missing neighbor takes the opposite one
    always_comb
    begin
        mid_px   = gw_reg[1][1];
        up_px    = s2_pos_reg.top   ? gw_reg[1][2] : gw_reg[1][0];
        down_px  = s2_pos_reg.bot   ? gw_reg[1][0] : gw_reg[1][2];
        left_px  = s2_pos_reg.left  ? gw_reg[2][1] : gw_reg[0][1];
        right_px = s2_pos_reg.right ? gw_reg[0][1] : gw_reg[2][1];
        lap_w = $signed({2'b00, mid_px, 2'b00}) - $signed({4'b0000, up_px})
              - $signed({4'b0000, down_px}) - $signed({4'b0000, left_px})
              - $signed({4'b0000, right_px});
        thr_s = $signed({2'b00, thr});
        priority if (lap_w > thr_s)
        begin
            code_w = lzce_pkg::LV_POS;
        end
        else if (lap_w < -thr_s)
        begin
            code_w = lzce_pkg::LV_NEG;
        end
        else
        begin
            code_w = lzce_pkg::LV_ZERO;
        end
    end

    assign lv_valid = s3_valid_reg;
    assign lv_lap   = s3_lap_reg;
    assign lv_code  = s3_code_reg;
    assign lv_col   = s3_col_reg;
    assign lv_tag   = s3_tag_reg;

endmodule

// File: hw/rtl/lzce_edge_stage.sv
// level line store, 3x3 level window and zero-crossing decision
module lzce_edge_stage #(
    parameter int MAX_WIDTH = lzce_pkg::DEF_MAX_WIDTH,
    parameter int CW        = $clog2(MAX_WIDTH)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              flush,
    input  logic                              in_valid,
    input  logic signed [lzce_pkg::LAP_W-1:0] in_lap,
    input  logic [lzce_pkg::LVL_W-1:0]        in_code,
    input  logic [CW-1:0]                     in_col,
    input  lzce_pkg::lzce_tag_t               in_tag,
    output logic                              res_valid,
    output lzce_pkg::lzce_result_t            res
);

    localparam int LW = lzce_pkg::LVL_W;
    localparam int AW = lzce_pkg::LAP_W;
    localparam int EW = 2*LW + AW;

    // entry: {level two rows up, level one row up, laplacian one row up}
    logic [EW-1:0] lvl_mem [MAX_WIDTH];
    logic [EW-1:0] lvl_rd_reg;

    logic                e1_valid_reg;
    logic [LW-1:0]       e1_code_reg;
    logic [AW-1:0]       e1_lap_reg;
    logic [CW-1:0]       e1_col_reg;
    lzce_pkg::lzce_tag_t e1_tag_reg;

    logic                e2_valid_reg;
    lzce_pkg::lzce_tag_t e2_tag_reg;

    logic [2:0][2:0][LW-1:0] lw_reg;
    logic [AW-1:0]           lap_right_reg;
    logic [AW-1:0]           lap_mid_reg;

    logic [2:0][LW-1:0] top_c, bot_c;
    logic [8:0][LW-1:0] c;
    logic               edge_hit;

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            lvl_rd_reg <= lvl_mem[in_col];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && e1_valid_reg)
        begin
            lvl_mem[e1_col_reg] <= {lvl_rd_reg[EW-LW-1:AW], e1_code_reg, e1_lap_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg <= 1'b0;
            e2_valid_reg <= 1'b0;
        end
        else if (flush)
        begin
            e1_valid_reg <= 1'b0;
            e2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            e1_valid_reg <= in_valid;
            e2_valid_reg <= e1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_code_reg <= in_code;
            e1_lap_reg  <= in_lap;
            e1_col_reg  <= in_col;
            e1_tag_reg  <= in_tag;
            e2_tag_reg  <= e1_tag_reg;
        end
        if (adv && e1_valid_reg)
        begin
            lw_reg[0]     <= lw_reg[1];
            lw_reg[1]     <= lw_reg[2];
            lw_reg[2][0]  <= lvl_rd_reg[EW-1:EW-LW];
            lw_reg[2][1]  <= lvl_rd_reg[EW-LW-1:AW];
            lw_reg[2][2]  <= e1_code_reg;
            lap_mid_reg   <= lap_right_reg;
            lap_right_reg <= lvl_rd_reg[AW-1:0];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            top_c[k] = e2_tag_reg.pos.top ? lw_reg[k][2] : lw_reg[k][0];
            bot_c[k] = e2_tag_reg.pos.bot ? lw_reg[k][0] : lw_reg[k][2];
        end
        // c is row-major, row 0 on top
        c[0] = e2_tag_reg.pos.left  ? top_c[2] : top_c[0];
        c[1] = top_c[1];
        c[2] = e2_tag_reg.pos.right ? top_c[0] : top_c[2];
        c[3] = e2_tag_reg.pos.left  ? lw_reg[2][1] : lw_reg[0][1];
        c[4] = lw_reg[1][1];
        c[5] = e2_tag_reg.pos.right ? lw_reg[0][1] : lw_reg[2][1];
        c[6] = e2_tag_reg.pos.left  ? bot_c[2] : bot_c[0];
        c[7] = bot_c[1];
        c[8] = e2_tag_reg.pos.right ? bot_c[0] : bot_c[2];

        edge_hit = 1'b0;
        if (c[4] == lzce_pkg::LV_ZERO)
        begin
            // opposite pair with one positive and one negative side
            for (int k = 0; k < 4; k++)
            begin
                if ((c[k] == lzce_pkg::LV_POS && c[8-k] == lzce_pkg::LV_NEG) ||
                    (c[k] == lzce_pkg::LV_NEG && c[8-k] == lzce_pkg::LV_POS))
                begin
                    edge_hit = 1'b1;
                end
            end
        end
        else if (c[4] == lzce_pkg::LV_POS)
        begin
            for (int k = 0; k < 9; k++)
            begin
                if (c[k] == lzce_pkg::LV_NEG)
                begin
                    edge_hit = 1'b1;
                end
            end
        end
    end

    assign res_valid    = e2_valid_reg && e2_tag_reg.emit;
    assign res.lap      = $signed(lap_mid_reg);
    assign res.level    = c[4];
    assign res.edge_res = edge_hit;
    assign res.last     = e2_tag_reg.last;

endmodule

// File: hw/rtl/lzce_out_fifo.sv
// two-entry result buffer between the pipeline and the output channel
module lzce_out_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   flush,
    input  logic                   push,
    input  lzce_pkg::lzce_result_t din,
    input  logic                   out_ready,
    output logic                   out_valid,
    output lzce_pkg::lzce_result_t dout,
    output logic                   full
);

    lzce_pkg::lzce_result_t ent_reg [2];
    logic                   wr_ptr_reg;
    logic                   rd_ptr_reg;
    logic [1:0]             cnt_reg;
    logic                   pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign full      = (cnt_reg == 2'd2);
    assign pop       = out_valid && out_ready;
    assign dout      = ent_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else if (flush)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// File: hw/rtl/laplacian_zero_crossing_edge_unit.sv
// top level of the laplacian zero-crossing edge unit
// Takes one transaction per clock while in_ready is high: a gray pixel in raster order, or a drain tick
// once the frame's pixels are in (drain ticks during a frame are taken and
// ignored, pixels after a frame count as drain ticks). The result for pixel p
// is released by transaction p + 2*W + 2 of the frame, so 2*W + 2 drain ticks
// flush a frame; the last result carries last_pixel and the next pixel starts
// a new frame. Each pixel passes a gray line store (one read and one write per
// clock) and a level line store of the same kind, each feeding a 3x3 window,
// so the rate is one transaction per clock unless a result meets a full output
// buffer; a two-entry output buffer keeps the input open while a result waits.
// A register write restarts the frame; the user makes it only while the unit is idle,
// as the block itself does not enforce this. The line stores need no clearing after reset.
module laplacian_zero_crossing_edge_unit #(
    parameter int MAX_WIDTH  = lzce_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lzce_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic [lzce_pkg::GRAY_W-1:0]         pixel,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [lzce_pkg::LAP_W-1:0]   laplacian,
    output logic [lzce_pkg::LVL_W-1:0]          level,
    output logic                                edge_res,
    output logic                                last_pixel,
    input  logic                                cfg_wr_en,
    input  logic [lzce_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lzce_pkg::CFG_DW-1:0]         cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 3);
    localparam int RST_W = (lzce_pkg::IMG_W_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                               : lzce_pkg::IMG_W_RESET;
    localparam int RST_H = (lzce_pkg::IMG_H_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                                : lzce_pkg::IMG_H_RESET;

    logic [WW-1:0]                w_reg, w_next;
    logic [HW-1:0]                h_reg, h_next;
    logic [lzce_pkg::THR_W-1:0]   thr_reg, thr_next;
    logic [CW-1:0]                tc_reg, tc_next;
    logic [RW-1:0]                tr_reg, tr_next;

    logic          cfg_restart;
    logic          adv, accept, step, in_frame, last_col;
    logic          tc_is0, tc_is1, tc_is2, tc_ge2;
    logic [RW-1:0] h_ext;
    logic [CW-1:0] a_col;
    lzce_pkg::lzce_pos_t a_pos;
    lzce_pkg::lzce_tag_t b_tag;

    logic                              lv_valid;
    logic signed [lzce_pkg::LAP_W-1:0] lv_lap;
    logic [lzce_pkg::LVL_W-1:0]        lv_code;
    logic [CW-1:0]                     lv_col;
    lzce_pkg::lzce_tag_t               lv_tag;

    logic                   res_valid;
    lzce_pkg::lzce_result_t res;
    lzce_pkg::lzce_result_t dout;
    logic                   fifo_full;

    logic [10:0] cfg_w;
    logic [12:0] cfg_h;

    // configuration registers, sizes clamped on the way in
    always_comb
    begin
        cfg_w       = cfg_data[10:0];
        cfg_h       = cfg_data[12:0];
        w_next      = w_reg;
        h_next      = h_reg;
        thr_next    = thr_reg;
        cfg_restart = 1'b0;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                lzce_pkg::REG_IMAGE_WIDTH:
                begin
                    cfg_restart = 1'b1;
                    if (cfg_w < 11'd3)
                        w_next = WW'(3);
                    else if (32'(cfg_w) > MAX_WIDTH)
                        w_next = WW'(MAX_WIDTH);
                    else
                        w_next = WW'(cfg_w);
                end
                lzce_pkg::REG_IMAGE_HEIGHT:
                begin
                    cfg_restart = 1'b1;
                    if (cfg_h < 13'd3)
                        h_next = HW'(3);
                    else if (32'(cfg_h) > MAX_HEIGHT)
                        h_next = HW'(MAX_HEIGHT);
                    else
                        h_next = HW'(cfg_h);
                end
                lzce_pkg::REG_THRESHOLD:
                begin
                    cfg_restart = 1'b1;
                    thr_next    = cfg_data[lzce_pkg::THR_W-1:0];
                end
                default:
                begin
                    cfg_restart = 1'b0;
                end
            endcase
        end
    end

    assign adv      = !(fifo_full && res_valid);
    assign in_ready = adv;
    assign accept   = in_valid && in_ready;
    assign h_ext    = RW'(h_reg);
    assign in_frame = (tr_reg < h_ext);
    assign step     = accept && (!in_frame || !action);
    assign last_col = (WW'(tc_reg) == w_reg - WW'(1));

    // border flags of the laplacian target (one row and column back) and of the
    // result target (two rows and columns back)
    always_comb
    begin
        tc_is0 = (tc_reg == CW'(0));
        tc_is1 = (tc_reg == CW'(1));
        tc_is2 = (tc_reg == CW'(2));
        tc_ge2 = !tc_is0 && !tc_is1;

        a_col       = tc_is0 ? CW'(w_reg - WW'(1)) : tc_reg - CW'(1);
        a_pos.top   = tc_is0 ? (tr_reg == RW'(2)) : (tr_reg == RW'(1));
        a_pos.bot   = tc_is0 ? (tr_reg == h_ext + RW'(1)) : (tr_reg == h_ext);
        a_pos.left  = tc_is1;
        a_pos.right = tc_is0;

        b_tag.pos.top   = tc_ge2 ? (tr_reg == RW'(2)) : (tr_reg == RW'(3));
        b_tag.pos.bot   = tc_ge2 ? (tr_reg == h_ext + RW'(1)) : (tr_reg == h_ext + RW'(2));
        b_tag.pos.left  = tc_is2;
        b_tag.pos.right = tc_is1;
        b_tag.emit      = tc_ge2 ? (tr_reg >= RW'(2) && tr_reg <= h_ext + RW'(1))
                                 : (tr_reg >= RW'(3) && tr_reg <= h_ext + RW'(2));
        b_tag.last      = tc_is1 && (tr_reg == h_ext + RW'(2));
    end

    always_comb
    begin
        tc_next = tc_reg;
        tr_next = tr_reg;
        priority if (cfg_restart)
        begin
            tc_next = '0;
            tr_next = '0;
        end
        else if (step && b_tag.last)
        begin
            tc_next = '0;
            tr_next = '0;
        end
        else if (step && last_col)
        begin
            tc_next = '0;
            tr_next = tr_reg + RW'(1);
        end
        else if (step)
        begin
            tc_next = tc_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg   <= WW'(RST_W);
            h_reg   <= HW'(RST_H);
            thr_reg <= lzce_pkg::THR_W'(lzce_pkg::THR_RESET);
            tc_reg  <= '0;
            tr_reg  <= '0;
        end
        else
        begin
            w_reg   <= w_next;
            h_reg   <= h_next;
            thr_reg <= thr_next;
            tc_reg  <= tc_next;
            tr_reg  <= tr_next;
        end
    end

    lzce_lap_stage #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_lap (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .flush    (cfg_restart),
        .step     (step),
        .col      (tc_reg),
        .pix      (pixel),
        .a_pos    (a_pos),
        .a_col    (a_col),
        .b_tag    (b_tag),
        .thr      (thr_reg),
        .lv_valid (lv_valid),
        .lv_lap   (lv_lap),
        .lv_code  (lv_code),
        .lv_col   (lv_col),
        .lv_tag   (lv_tag)
    );

    lzce_edge_stage #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_edge (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .flush     (cfg_restart),
        .in_valid  (lv_valid),
        .in_lap    (lv_lap),
        .in_code   (lv_code),
        .in_col    (lv_col),
        .in_tag    (lv_tag),
        .res_valid (res_valid),
        .res       (res)
    );

    lzce_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .flush     (cfg_restart),
        .push      (res_valid && adv),
        .din       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .dout      (dout),
        .full      (fifo_full)
    );

    assign laplacian  = dout.lap;
    assign level      = dout.level;
    assign edge_res   = dout.edge_res;
    assign last_pixel = dout.last;

endmodule

// File: hw/rtl/lzce_checker.sv
// port-level checks of the edge unit and their binding to the top level
module lzce_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [lzce_pkg::LAP_W-1:0] laplacian,
    input logic [lzce_pkg::LVL_W-1:0]        level,
    input logic                              edge_res,
    input logic                              last_pixel
);

    // a stalled result transaction keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(laplacian) && $stable(level)
                                    && $stable(edge_res) && $stable(last_pixel))
        else $error("result changed while stalled");

    a_lap_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (laplacian >= -11'sd1020) && (laplacian <= 11'sd1020))
        else $error("laplacian out of range");

    // level must agree with the sign of the response
    a_level_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (level == lzce_pkg::LV_ZERO) ||
                      (level == lzce_pkg::LV_POS && laplacian > 11'sd0) ||
                      (level == lzce_pkg::LV_NEG && laplacian < 11'sd0))
        else $error("level does not match laplacian");

    a_neg_no_edge: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && level == lzce_pkg::LV_NEG |-> !edge_res)
        else $error("edge flagged on negative pixel");

endmodule

bind laplacian_zero_crossing_edge_unit lzce_checker u_lzce_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .laplacian  (laplacian),
    .level      (level),
    .edge_res   (edge_res),
    .last_pixel (last_pixel)
);
